// ===== hw/rtl/mpfb_pkg.sv =====
// Shared types, codes and constants of the max pooling forward/backward unit.
`timescale 1ns / 1ps
`default_nettype none
package mpfb_pkg;

    localparam int ACTION_W  = 2;
    localparam int SAMPLE_W  = 16;
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 24;
    localparam int POS_W     = 14;
    localparam int ERR_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 8;
    localparam int WIN_W     = 4;
    localparam int CH_W      = 7;
    localparam int DIM_W     = 8;
    localparam int CHH_W     = CH_W + DIM_W;
    localparam int TOT_W     = CH_W + DIM_W + DIM_W;

    localparam logic [ACTION_W-1:0] ACT_FWD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BWD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DRAIN = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_POOL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SIZE   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ORDER  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EXCESS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;

    localparam logic [WIN_W-1:0] DEF_WINDOW   = 4'd2;
    localparam logic [WIN_W-1:0] DEF_STRIDE   = 4'd2;
    localparam logic [CH_W-1:0]  DEF_CHANNELS = 7'd1;
    localparam logic [DIM_W-1:0] DEF_HEIGHT   = 8'd28;
    localparam logic [DIM_W-1:0] DEF_WIDTH    = 8'd28;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]         result_kind;
        logic signed [VALUE_W-1:0] result_value;
        logic [POS_W-1:0]          position;
        logic                      last;
        logic [ERR_W-1:0]          error_code;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic             load_item;
        logic             clear;
        logic             fwd;
        logic             pool;
        logic             grd_b;
        logic             grd_c;
        logic             drn_a;
        logic             drn_b;
        logic             set_err;
        logic [ERR_W-1:0] err_code;
        logic             emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic                cfg_written;
        logic [ACTION_W-1:0] action;
        logic                sizes_ok;
        logic                need_restart;
        logic                forward_done;
        logic                hit;
        logic                walk_done;
        logic                clear_done;
        logic                grad_over;
        logic                out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mpfb_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface mpfb_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/max_pool_forward_backward_unit.sv =====
// Top level of the max pooling forward/backward unit.
//
//  channel | role  | payload
//  --------+-------+------------------------------------------------
//  req     | sink  | action, sample
//  cfg     | sink  | index, value (window_size/stride/channels/height/width)
//  rsp     | source| result_kind, result_value, position, last, error_code
//
// A forward sample that completes no window is only stored; one that completes a
// window walks the sample store through its single read port, one entry a cycle.
// A backward gradient takes an argmax read, a gradient read and a write.
// After reset, any register write and each new forward pass, the gradient store is
// cleared; no item is taken meanwhile.
// A held result stalls the unit only once the next result is ready; until then items are taken.
`timescale 1ns / 1ps
`default_nettype none
module max_pool_forward_backward_unit #(
    parameter int MAX_ELEMENTS = 16384,
    parameter int MAX_WINDOW   = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mpfb_chan_if.sink   req,
    mpfb_chan_if.sink   cfg,
    mpfb_chan_if.source rsp
);
    mpfb_pkg::ctrl_cmd_t cmd;
    mpfb_pkg::dp_status_t st;

    mpfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    mpfb_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cfg      (cfg),
        .rsp      (rsp),
        .cmd      (cmd),
        .st       (st)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mpfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_ctrl.sv =====
// Sequencing state machine of the max pooling forward/backward unit.
`timescale 1ns / 1ps
`default_nettype none
module mpfb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire mpfb_pkg::dp_status_t st,
    output mpfb_pkg::ctrl_cmd_t      cmd
);
    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_DECODE = 12'b000000000100,
        S_FWD    = 12'b000000001000,
        S_WALK   = 12'b000000010000,
        S_POOL   = 12'b000000100000,
        S_GRD_A  = 12'b000001000000,
        S_GRD_B  = 12'b000010000000,
        S_GRD_C  = 12'b000100000000,
        S_DRN_A  = 12'b001000000000,
        S_DRN_B  = 12'b010000000000,
        S_EMIT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_done && !st.cfg_written)
                begin
                    state_next = pend_reg ? S_FWD : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                cmd.load_item = req_valid;
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (st.action == mpfb_pkg::ACT_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (!st.sizes_ok)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = mpfb_pkg::ERR_SIZE;
                    state_next   = S_EMIT;
                end
                else if (st.action == mpfb_pkg::ACT_FWD)
                begin
                    if (st.need_restart)
                    begin
                        state_next = S_CLEAR;
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FWD;
                    end
                end
                else if (!st.forward_done)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = mpfb_pkg::ERR_ORDER;
                    state_next   = S_EMIT;
                end
                else if (st.action == mpfb_pkg::ACT_BWD)
                begin
                    if (st.grad_over)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = mpfb_pkg::ERR_EXCESS;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_GRD_A;
                    end
                end
                else
                begin
                    state_next = S_DRN_A;
                end
            end
            S_FWD:
            begin
                cmd.fwd    = 1'b1;
                state_next = st.hit ? S_WALK : S_IDLE;
            end
            S_WALK:
            begin
                if (st.walk_done)
                begin
                    state_next = S_POOL;
                end
            end
            S_POOL:
            begin
                cmd.pool   = 1'b1;
                state_next = S_EMIT;
            end
            S_GRD_A:
            begin
                state_next = S_GRD_B;
            end
            S_GRD_B:
            begin
                cmd.grd_b  = 1'b1;
                state_next = S_GRD_C;
            end
            S_GRD_C:
            begin
                cmd.grd_c  = 1'b1;
                state_next = S_IDLE;
            end
            S_DRN_A:
            begin
                cmd.drn_a  = 1'b1;
                state_next = S_DRN_B;
            end
            S_DRN_B:
            begin
                cmd.drn_b  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        if (st.cfg_written && state_reg != S_CLEAR)
        begin
            state_next = S_CLEAR;
            pend_next  = 1'b0;
        end
        else if (st.cfg_written)
        begin
            pend_next = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_dp.sv =====
// Datapath: configuration, counters, stores, window walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module mpfb_dp #(
    parameter int MAX_ELEMENTS = 16384,
    parameter int MAX_WINDOW   = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mpfb_pkg::item_t      req_data,
    mpfb_chan_if.sink                 cfg,
    mpfb_chan_if.source               rsp,
    input  wire mpfb_pkg::ctrl_cmd_t  cmd,
    output mpfb_pkg::dp_status_t      st
);
    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int TOT_W = mpfb_pkg::TOT_W;
    localparam int WIN_W = mpfb_pkg::WIN_W;
    localparam int DIM_W = mpfb_pkg::DIM_W;
    localparam int CH_W  = mpfb_pkg::CH_W;

    logic [WIN_W-1:0] window_reg, stride_reg;
    logic [CH_W-1:0]  channels_reg;
    logic [DIM_W-1:0] height_reg, width_reg;
    logic             cfg_hit;

    logic [mpfb_pkg::CHH_W-1:0] chh_reg;
    logic [TOT_W-1:0]           total_reg;
    logic                       sizes_ok_reg;

    logic [mpfb_pkg::ACTION_W-1:0]        action_reg;
    logic signed [mpfb_pkg::SAMPLE_W-1:0] sample_reg;

    logic [CW-1:0]    sample_cnt_reg, pooled_cnt_reg, grad_cnt_reg, drain_cnt_reg;
    logic             fwd_done_reg;
    logic [DIM_W-1:0] col_reg, row_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [WIN_W-1:0] cdn_reg, rdn_reg, km1;
    logic             hit, last_pool_reg;

    logic             issue_reg, rd_valid_reg, rd_first_reg, rd_last_reg;
    logic [WIN_W-1:0] i_reg, j_reg;
    logic [AW-1:0]    row_base_reg, walk_addr, rd_pos_reg, base, best_pos_reg;
    logic signed [mpfb_pkg::SAMPLE_W-1:0] best_reg;

    logic [AW-1:0]    clr_addr_reg, idx_reg, d_reg, d_sel;
    logic             drn_fin;

    logic [mpfb_pkg::SAMPLE_W-1:0] smp_rdata;
    logic [AW-1:0]                 amx_rdata;
    logic [mpfb_pkg::VALUE_W-1:0]  grd_rdata, grd_wdata, sat_sum;
    logic signed [mpfb_pkg::VALUE_W:0] sum;
    logic                          grd_we;
    logic [AW-1:0]                 grd_waddr, grd_raddr;

    mpfb_pkg::result_t res_reg, out_data_reg;
    logic              out_valid_reg;

    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid && (cfg.data.index <= mpfb_pkg::REG_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= mpfb_pkg::DEF_WINDOW;
            stride_reg   <= mpfb_pkg::DEF_STRIDE;
            channels_reg <= mpfb_pkg::DEF_CHANNELS;
            height_reg   <= mpfb_pkg::DEF_HEIGHT;
            width_reg    <= mpfb_pkg::DEF_WIDTH;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                mpfb_pkg::REG_WINDOW:   window_reg   <= cfg.data.value[WIN_W-1:0];
                mpfb_pkg::REG_STRIDE:   stride_reg   <= cfg.data.value[WIN_W-1:0];
                mpfb_pkg::REG_CHANNELS: channels_reg <= cfg.data.value[CH_W-1:0];
                mpfb_pkg::REG_HEIGHT:   height_reg   <= cfg.data.value[DIM_W-1:0];
                mpfb_pkg::REG_WIDTH:    width_reg    <= cfg.data.value[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chh_reg      <= '0;
            total_reg    <= '0;
            sizes_ok_reg <= 1'b0;
        end
        else
        begin
            chh_reg      <= mpfb_pkg::CHH_W'(channels_reg * height_reg);
            total_reg    <= TOT_W'(chh_reg * width_reg);
            sizes_ok_reg <= (window_reg != '0) && (32'(window_reg) <= 32'(MAX_WINDOW))
                            && (stride_reg != '0) && (channels_reg != '0)
                            && (height_reg >= DIM_W'(window_reg))
                            && (width_reg >= DIM_W'(window_reg))
                            && (32'(total_reg) <= 32'(MAX_ELEMENTS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= req_data.action;
            sample_reg <= req_data.sample;
        end
    end

    assign km1 = window_reg - WIN_W'(1);
    assign hit = (cdn_reg == '0) && (rdn_reg == '0);
    assign base = sample_cnt_reg[AW-1:0] - AW'(km1 * width_reg) - AW'(km1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            pooled_cnt_reg <= '0;
            grad_cnt_reg   <= '0;
            drain_cnt_reg  <= '0;
            fwd_done_reg   <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            ch_reg         <= '0;
            cdn_reg        <= '0;
            rdn_reg        <= '0;
        end
        else if (cmd.clear)
        begin
            sample_cnt_reg <= '0;
            pooled_cnt_reg <= '0;
            grad_cnt_reg   <= '0;
            drain_cnt_reg  <= '0;
            fwd_done_reg   <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            ch_reg         <= '0;
            cdn_reg        <= km1;
            rdn_reg        <= km1;
        end
        else
        begin
            if (cmd.fwd)
            begin
                sample_cnt_reg <= sample_cnt_reg + CW'(1);
                if (TOT_W'(sample_cnt_reg) + TOT_W'(1) == total_reg)
                begin
                    fwd_done_reg <= 1'b1;
                end
                if (col_reg == width_reg - DIM_W'(1))
                begin
                    col_reg <= '0;
                    cdn_reg <= km1;
                    if (row_reg == height_reg - DIM_W'(1))
                    begin
                        row_reg <= '0;
                        ch_reg  <= ch_reg + CH_W'(1);
                        rdn_reg <= km1;
                    end
                    else
                    begin
                        row_reg <= row_reg + DIM_W'(1);
                        rdn_reg <= (rdn_reg == '0) ? stride_reg - WIN_W'(1)
                                                   : rdn_reg - WIN_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + DIM_W'(1);
                    cdn_reg <= (cdn_reg == '0) ? stride_reg - WIN_W'(1)
                                               : cdn_reg - WIN_W'(1);
                end
            end
            if (cmd.pool)
            begin
                pooled_cnt_reg <= pooled_cnt_reg + CW'(1);
            end
            if (cmd.grd_c)
            begin
                grad_cnt_reg <= grad_cnt_reg + CW'(1);
            end
            if (cmd.drn_b)
            begin
                if (drn_fin)
                begin
                    drain_cnt_reg <= '0;
                    grad_cnt_reg  <= '0;
                end
                else
                begin
                    drain_cnt_reg <= CW'(d_reg) + CW'(1);
                end
            end
        end
    end

    // window walk: issue one read a cycle, compare on returned data
    assign walk_addr = row_base_reg + AW'(j_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else
        begin
            rd_valid_reg <= issue_reg;
            rd_first_reg <= issue_reg && (i_reg == '0) && (j_reg == '0);
            rd_last_reg  <= issue_reg && (i_reg == km1) && (j_reg == km1);
            if (cmd.fwd && hit)
            begin
                issue_reg <= 1'b1;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            else if (issue_reg)
            begin
                if (j_reg == km1)
                begin
                    j_reg <= '0;
                    if (i_reg == km1)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg <= i_reg + WIN_W'(1);
                    end
                end
                else
                begin
                    j_reg <= j_reg + WIN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg <= walk_addr;
        if (cmd.fwd && hit)
        begin
            row_base_reg  <= base;
            last_pool_reg <= (ch_reg == channels_reg - CH_W'(1))
                             && ({1'b0, row_reg} + 9'(stride_reg) >= {1'b0, height_reg})
                             && ({1'b0, col_reg} + 9'(stride_reg) >= {1'b0, width_reg});
        end
        else if (issue_reg && (j_reg == km1))
        begin
            row_base_reg <= row_base_reg + AW'(width_reg);
        end
        if (rd_valid_reg && (rd_first_reg || ($signed(smp_rdata) > best_reg)))
        begin
            best_reg     <= $signed(smp_rdata);
            best_pos_reg <= rd_pos_reg;
        end
    end

    // gradient store: clearing pass, read-modify-write, drain
    assign d_sel   = (32'(drain_cnt_reg) >= 32'(total_reg)) ? '0 : drain_cnt_reg[AW-1:0];
    assign drn_fin = (TOT_W'(d_reg) + TOT_W'(1) == total_reg);
    assign sum     = $signed({grd_rdata[mpfb_pkg::VALUE_W-1], grd_rdata})
                     + (mpfb_pkg::VALUE_W + 1)'(sample_reg);
    assign sat_sum = (sum[mpfb_pkg::VALUE_W] != sum[mpfb_pkg::VALUE_W-1])
                     ? {sum[mpfb_pkg::VALUE_W], {(mpfb_pkg::VALUE_W-1){~sum[mpfb_pkg::VALUE_W]}}}
                     : sum[mpfb_pkg::VALUE_W-1:0];

    assign grd_we    = cmd.clear || cmd.grd_c || cmd.drn_b;
    assign grd_waddr = cmd.clear ? clr_addr_reg : (cmd.grd_c ? idx_reg : d_reg);
    assign grd_wdata = cmd.grd_c ? sat_sum : '0;
    assign grd_raddr = cmd.drn_a ? d_sel : amx_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear && !cfg_hit)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
        else
        begin
            clr_addr_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grd_b)
        begin
            idx_reg <= amx_rdata;
        end
        if (cmd.drn_a)
        begin
            d_reg <= d_sel;
        end
    end

    mpfb_ram #(.WIDTH(mpfb_pkg::SAMPLE_W), .DEPTH(MAX_ELEMENTS)) u_sample_ram (
        .clk   (clk),
        .we    (cmd.fwd),
        .waddr (sample_cnt_reg[AW-1:0]),
        .wdata (sample_reg),
        .raddr (walk_addr),
        .rdata (smp_rdata)
    );

    mpfb_ram #(.WIDTH(AW), .DEPTH(MAX_ELEMENTS)) u_argmax_ram (
        .clk   (clk),
        .we    (cmd.pool),
        .waddr (pooled_cnt_reg[AW-1:0]),
        .wdata (best_pos_reg),
        .raddr (grad_cnt_reg[AW-1:0]),
        .rdata (amx_rdata)
    );

    mpfb_ram #(.WIDTH(mpfb_pkg::VALUE_W), .DEPTH(MAX_ELEMENTS)) u_grad_ram (
        .clk   (clk),
        .we    (grd_we),
        .waddr (grd_waddr),
        .wdata (grd_wdata),
        .raddr (grd_raddr),
        .rdata (grd_rdata)
    );

    // result staging and output register
    always_ff @(posedge clk)
    begin
        if (cmd.set_err)
        begin
            res_reg.result_kind  <= mpfb_pkg::KIND_ERR;
            res_reg.result_value <= '0;
            res_reg.position     <= '0;
            res_reg.last         <= 1'b0;
            res_reg.error_code   <= cmd.err_code;
        end
        else if (cmd.pool)
        begin
            res_reg.result_kind  <= mpfb_pkg::KIND_POOL;
            res_reg.result_value <= mpfb_pkg::VALUE_W'(best_reg);
            res_reg.position     <= mpfb_pkg::POS_W'(best_pos_reg);
            res_reg.last         <= last_pool_reg;
            res_reg.error_code   <= mpfb_pkg::ERR_NONE;
        end
        else if (cmd.drn_b)
        begin
            res_reg.result_kind  <= mpfb_pkg::KIND_GRAD;
            res_reg.result_value <= $signed(grd_rdata);
            res_reg.position     <= mpfb_pkg::POS_W'(d_reg);
            res_reg.last         <= drn_fin;
            res_reg.error_code   <= mpfb_pkg::ERR_NONE;
        end
        if (cmd.emit)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        st.cfg_written  = cfg_hit;
        st.action       = action_reg;
        st.sizes_ok     = sizes_ok_reg;
        st.need_restart = fwd_done_reg || (TOT_W'(sample_cnt_reg) >= total_reg);
        st.forward_done = fwd_done_reg;
        st.hit          = hit;
        st.walk_done    = rd_valid_reg && rd_last_reg;
        st.clear_done   = cmd.clear && (clr_addr_reg == AW'(MAX_ELEMENTS - 1));
        st.grad_over    = (grad_cnt_reg >= pooled_cnt_reg);
        st.out_free     = !out_valid_reg || rsp.ready;
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || rsp.ready))
        else $error("result loaded over an untaken result");
    a_grad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        grad_cnt_reg <= pooled_cnt_reg)
        else $error("gradient count passed pooled count");
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pooled_cnt_reg <= sample_cnt_reg)
        else $error("pooled count passed sample count");
`endif
endmodule
`default_nettype wire

// ===== tb/max_pool_forward_backward_unit_tb.sv =====
// Self-checking testbench of the max pooling forward/backward unit.
`timescale 1ns / 1ps
module max_pool_forward_backward_unit_tb;
    import mpfb_pkg::*;

    localparam int MAX_ELEMENTS = 16384;
    localparam int MAX_WINDOW   = 8;
    localparam int SETTLE       = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mpfb_chan_if #(.payload_t(item_t))   req_if ();
    mpfb_chan_if #(.payload_t(cfg_t))    cfg_if ();
    mpfb_chan_if #(.payload_t(result_t)) rsp_if ();

    max_pool_forward_backward_unit #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .MAX_WINDOW(MAX_WINDOW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if.sink),
        .cfg(cfg_if.sink),
        .rsp(rsp_if.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pooling state mirror
    int unsigned pool_win, pool_stride, n_chan, n_rows, n_cols;
    logic signed [SAMPLE_W-1:0] sample_mem [MAX_ELEMENTS];
    int unsigned argmax_mem [MAX_ELEMENTS];
    int grad_mem [MAX_ELEMENTS];
    int unsigned fwd_cnt, pool_cnt, grad_cnt, drain_cnt;
    bit fwd_done;

    result_t expected_results [$];
    int fail_cnt = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_cnt = 0;

    function automatic void restart_pass();
        fwd_cnt = 0;
        pool_cnt = 0;
        grad_cnt = 0;
        drain_cnt = 0;
        fwd_done = 1'b0;
        foreach (grad_mem[i]) grad_mem[i] = 0;
    endfunction

    function automatic bit shape_valid();
        return pool_win >= 1 && pool_win <= MAX_WINDOW && pool_stride >= 1 &&
               n_chan >= 1 && n_rows >= pool_win && n_cols >= pool_win &&
               n_chan * n_rows * n_cols <= MAX_ELEMENTS;
    endfunction

    function automatic int unsigned elem_total();
        return n_chan * n_rows * n_cols;
    endfunction

    function automatic int unsigned pooled_total();
        return n_chan * ((n_rows - pool_win) / pool_stride + 1) *
               ((n_cols - pool_win) / pool_stride + 1);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_VAL_W-1:0] val);
        case (idx)
            REG_WINDOW:   pool_win = val[WIN_W-1:0];
            REG_STRIDE:   pool_stride = val[WIN_W-1:0];
            REG_CHANNELS: n_chan = val[CH_W-1:0];
            REG_HEIGHT:   n_rows = val;
            REG_WIDTH:    n_cols = val;
            default:      return;
        endcase
        restart_pass();
    endfunction

    function automatic result_t error_result(input logic [ERR_W-1:0] code);
        result_t r;
        r = '0;
        r.result_kind = KIND_ERR;
        r.error_code = code;
        return r;
    endfunction

    function automatic bit pool_step(input item_t it, output result_t r);
        int unsigned total, p, plane, ch, row, col, k, r0, c0, q, best_pos;
        int best, acc, v;
        r = '0;
        if (it.action == ACT_NONE)
            return 1'b0;
        if (!shape_valid())
        begin
            r = error_result(ERR_SIZE);
            return 1'b1;
        end
        total = elem_total();
        if (it.action == ACT_FWD)
        begin
            k = pool_win;
            if (fwd_done || fwd_cnt >= total)
                restart_pass();
            p = fwd_cnt;
            sample_mem[p] = it.sample;
            fwd_cnt = p + 1;
            if (fwd_cnt == total)
                fwd_done = 1'b1;
            plane = n_rows * n_cols;
            ch = p / plane;
            row = (p % plane) / n_cols;
            col = p % n_cols;
            if (row + 1 >= k && (row + 1 - k) % pool_stride == 0 &&
                col + 1 >= k && (col + 1 - k) % pool_stride == 0)
            begin
                r0 = row + 1 - k;
                c0 = col + 1 - k;
                best_pos = (ch * n_rows + r0) * n_cols + c0;
                best = sample_mem[best_pos];
                for (int i = 0; i < k; i++)
                    for (int j = 0; j < k; j++)
                    begin
                        q = (ch * n_rows + r0 + i) * n_cols + c0 + j;
                        if (int'(sample_mem[q]) > best)
                        begin
                            best = sample_mem[q];
                            best_pos = q;
                        end
                    end
                argmax_mem[pool_cnt] = best_pos;
                pool_cnt++;
                r.result_kind = KIND_POOL;
                r.result_value = best[VALUE_W-1:0];
                r.position = best_pos[POS_W-1:0];
                r.last = (pool_cnt == pooled_total());
                r.error_code = ERR_NONE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!fwd_done)
        begin
            r = error_result(ERR_ORDER);
            return 1'b1;
        end
        if (it.action == ACT_BWD)
        begin
            if (grad_cnt >= pool_cnt)
            begin
                r = error_result(ERR_EXCESS);
                return 1'b1;
            end
            q = argmax_mem[grad_cnt];
            acc = grad_mem[q] + int'(it.sample);
            if (acc > 8388607) acc = 8388607;
            if (acc < -8388608) acc = -8388608;
            grad_mem[q] = acc;
            grad_cnt++;
            return 1'b0;
        end
        p = drain_cnt;
        if (p >= total)
            p = 0;
        v = grad_mem[p];
        grad_mem[p] = 0;
        r.result_kind = KIND_GRAD;
        r.result_value = v[VALUE_W-1:0];
        r.position = p[POS_W-1:0];
        r.last = (p + 1 == total);
        r.error_code = ERR_NONE;
        if (p + 1 == total)
        begin
            drain_cnt = 0;
            grad_cnt = 0;
        end
        else
            drain_cnt = p + 1;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_req > 0)
        begin
            hold_cnt <= hold_req;
            hold_req = 0;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(negedge clk)
    begin
        result_t want, got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (expected_results.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result %p", $time, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.result_kind !== want.result_kind ||
                    got.result_value !== want.result_value ||
                    got.position !== want.position || got.last !== want.last ||
                    got.error_code !== want.error_code)
                begin
                    fail_cnt++;
                    $display("%0t: expected %p, actual %p", $time, want, got);
                end
            end
        end
    end

    task automatic send_req(input logic [ACTION_W-1:0] act,
                            input logic [SAMPLE_W-1:0] smp);
        item_t it;
        result_t r;
        bit ok;
        it.action = act;
        it.sample = smp;
        if ($urandom_range(99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= it;
        do
        begin
            @(negedge clk);
            ok = req_if.ready;
            @(posedge clk);
        end while (!ok);
        if (pool_step(it, r))
            expected_results.push_back(r);
    endtask

    task automatic wait_idle(input int extra);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_VAL_W-1:0] val);
        bit ok;
        wait_idle(SETTLE);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: idx, value: val};
        do
        begin
            @(negedge clk);
            ok = cfg_if.ready;
            @(posedge clk);
        end while (!ok);
        cfg_if.valid <= 1'b0;
        apply_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_shape(input int w, input int s, input int c, input int h,
                             input int wd);
        if (w != pool_win) write_reg(REG_WINDOW, CFG_VAL_W'(w));
        if (s != pool_stride) write_reg(REG_STRIDE, CFG_VAL_W'(s));
        if (c != n_chan) write_reg(REG_CHANNELS, CFG_VAL_W'(c));
        if (h != n_rows) write_reg(REG_HEIGHT, CFG_VAL_W'(h));
        if (wd != n_cols) write_reg(REG_WIDTH, CFG_VAL_W'(wd));
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 78; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 78; end
            default: begin gap_pct = 34; stall_pct = 34; end
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
        case (mode)
            0: return SAMPLE_W'($urandom_range(3));
            1: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_pass();
        int unsigned total, n_grad, n_drain;
        int mode;
        total = elem_total();
        mode = $urandom_range(2);
        for (int i = 0; i < total; i++)
        begin
            send_req(ACT_FWD, pick_sample(mode));
            if (i + 1 < total && $urandom_range(99) < 4)
                send_req(ACTION_W'($urandom_range(ACT_BWD, ACT_NONE)), SAMPLE_W'($urandom));
        end
        n_grad = pooled_total();
        if ($urandom_range(3) == 0) n_grad += $urandom_range(1, 2);
        else if ($urandom_range(3) == 0) n_grad = $urandom_range(n_grad);
        for (int i = 0; i < n_grad; i++)
            send_req(ACT_BWD, SAMPLE_W'($urandom));
        n_drain = total;
        if ($urandom_range(3) == 0) n_drain += $urandom_range(1, 3);
        for (int i = 0; i < n_drain; i++)
            send_req(ACT_DRAIN, SAMPLE_W'($urandom));
    endtask

    task automatic test_order_errors();
        send_req(ACT_BWD, 16'h1234);
        send_req(ACT_DRAIN, 16'h0000);
        send_req(ACT_NONE, 16'hffff);
        send_req(ACT_FWD, 16'h0100);
        send_req(ACT_FWD, 16'hff00);
        send_req(ACT_DRAIN, 16'h0000);
    endtask

    task automatic test_small_pass();
        logic [SAMPLE_W-1:0] vals [12] = '{16'h8000, 16'h7fff, 16'h7fff,
                                         16'h0005, 16'hffff, 16'h0000,
                                         16'h0007, 16'h0007, 16'h0007,
                                         16'h0007, 16'h0007, 16'h0007};
        logic [SAMPLE_W-1:0] grads [4] = '{16'h7fff, 16'h8000, 16'h0001, 16'hffff};
        set_shape(2, 1, 2, 2, 3);
        foreach (vals[i]) send_req(ACT_FWD, vals[i]);
        foreach (grads[i]) send_req(ACT_BWD, grads[i]);
        send_req(ACT_BWD, 16'h0002);
        repeat (13) send_req(ACT_DRAIN, 16'h0000);
    endtask

    task automatic test_bad_sizes();
        logic [CFG_IDX_W-1:0] idx [8] = '{REG_WINDOW, REG_WINDOW, REG_STRIDE,
                                        REG_STRIDE, REG_CHANNELS, REG_CHANNELS,
                                        REG_HEIGHT, REG_WIDTH};
        logic [CFG_VAL_W-1:0] val [8] = '{8'd0, 8'd15, 8'd0, 8'd2, 8'd0, 8'd127,
                                        8'd255, 8'd128};
        for (int i = 0; i < 8; i++)
        begin
            write_reg(idx[i], val[i]);
            send_req(ACT_FWD, 16'h5555);
            send_req(ACT_BWD, 16'haaaa);
            send_req(ACT_DRAIN, 16'h0000);
        end
        send_req(ACT_NONE, 16'h0000);
        set_shape(8, 8, 64, 128, 128);
        send_req(ACT_FWD, 16'h0001);
        set_shape(2, 2, 1, 1, 4);
        send_req(ACT_FWD, 16'h0001);
    endtask

    task automatic test_extreme_shapes();
        set_shape(8, 8, 1, 8, 8);
        for (int i = 0; i < 64; i++)
            send_req(ACT_FWD, (i == 37) ? 16'h7fff : SAMPLE_W'(16'h8000 + i));
        send_req(ACT_BWD, 16'h8000);
        send_req(ACT_BWD, 16'h7fff);
        repeat (4) send_req(ACT_DRAIN, 16'h0000);
        set_shape(1, 8, 1, 128, 1);
        for (int i = 0; i < 128; i++)
            send_req(ACT_FWD, SAMPLE_W'($urandom));
        send_req(ACT_DRAIN, 16'h0000);
    endtask

    task automatic test_backpressure();
        set_idling(0);
        set_shape(1, 1, 1, 6, 6);
        hold_req = 300;
        for (int i = 0; i < 36; i++)
            send_req(ACT_FWD, SAMPLE_W'($urandom));
        wait_idle(SETTLE);
    endtask

    task automatic test_random_shapes();
        int w;
        for (int n = 0; n < 4; n++)
        begin
            set_idling(n);
            w = $urandom_range(1, 3);
            set_shape(w, $urandom_range(1, 3), 1,
                      $urandom_range(w, 4), $urandom_range(w, 4));
            run_pass();
        end
    endtask

    initial
    begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        rsp_if.ready = 1'b0;
        pool_win = DEF_WINDOW;
        pool_stride = DEF_STRIDE;
        n_chan = DEF_CHANNELS;
        n_rows = DEF_HEIGHT;
        n_cols = DEF_WIDTH;
        foreach (sample_mem[i]) sample_mem[i] = '0;
        foreach (argmax_mem[i]) argmax_mem[i] = 0;
        restart_pass();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_order_errors();
        test_small_pass();
        test_bad_sizes();
        set_idling(3);
        test_extreme_shapes();
        test_backpressure();
        test_random_shapes();
        wait_idle(SETTLE);
        if (fail_cnt == 0)
            $display("max_pool_forward_backward_unit: match");
        else
            $display("max_pool_forward_backward_unit: mismatch");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("max_pool_forward_backward_unit: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/mpfb_pkg.sv
hw/rtl/mpfb_chan_if.sv
hw/rtl/mpfb_ram.sv
hw/rtl/mpfb_ctrl.sv
hw/rtl/mpfb_dp.sv
hw/rtl/max_pool_forward_backward_unit.sv
tb/max_pool_forward_backward_unit_tb.sv
